// ===== hdl/lrusc_pkg.sv =====
// shared types and constants for the lru set-associative cache simulator
// used by lrusc_way_select and lru_set_assoc_cache_sim; depends on nothing
package lrusc_pkg;

  // default geometry
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 64;

  // configuration register widths and reset values
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd2;

  // access kinds
  typedef enum logic [1:0] {
    KIND_FETCH  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_MODIFY = 2'd3
  } kind_t;

  // control sequence
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_t;

  // lookup outcome for one set
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

endpackage

// ===== hdl/lru_set_assoc_cache_sim.sv =====
// Set-associative LRU cache hit/miss counter over a memory access trace.
// Input channel (in_valid/in_stall) carries kind and address; one result per
// transfer leaves on the output channel (out_valid/out_stall) as hit_count,
// miss_count and evict_count. Instruction fetches give all zero counts.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes set_bits,
// block_bits and ways; cfg_ready is always high and writes belong to idle time.
// The set row is read from the tag and meta memories in the accept cycle
// and written back in the evaluate state, where the result register loads.
// No new access is taken until the current one leaves the evaluate state,
// as the set row is read once and then written back. A modify costs no more:
// its store half always hits the line the load half just made most recent.
// The result stays in its register while out_stall is high; the next access
// may still be taken, but its write-back waits until that result is taken.
// Reset clears the configuration to set_bits 4, block_bits 4, ways 1, and
// marks every set row empty at once through per-row flags, so there is no
// clearing pass and the block takes an access in the first cycle after reset.
// depends on lrusc_pkg and lrusc_way_select
module lru_set_assoc_cache_sim #(
  parameter int MAX_SET_BITS = lrusc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = lrusc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = lrusc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             kind,
  input  logic [63:0]                            address,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             hit_count,
  output logic                                   miss_count,
  output logic                                   evict_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lrusc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lrusc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = 1 << MAX_SET_BITS;
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WN_W  = $clog2(MAX_WAYS + 1);
  localparam int WC_W  = (WN_W > lrusc_pkg::WAYS_W) ? WN_W : lrusc_pkg::WAYS_W;
  localparam logic [lrusc_pkg::SET_BITS_W-1:0] SET_CAP =
    lrusc_pkg::SET_BITS_W'((MAX_SET_BITS < 7) ? MAX_SET_BITS : 7);
  localparam logic [WC_W-1:0] WAY_CAP = WC_W'(MAX_WAYS);

  // configuration registers
  logic [lrusc_pkg::SET_BITS_W-1:0]   set_bits;
  logic [lrusc_pkg::BLOCK_BITS_W-1:0] block_bits;
  logic [lrusc_pkg::WAYS_W-1:0]       ways;

  // control
  lrusc_pkg::state_t state;
  lrusc_pkg::state_t state_next;
  logic              do_eval;
  logic              wr_en;

  // latched access
  lrusc_pkg::kind_t        kind_q;
  logic [SET_W-1:0]        set_q;
  logic [ADDR_WIDTH-1:0]   tag_q;

  // address split
  logic [ADDR_WIDTH-1:0]             addr;
  logic [lrusc_pkg::SET_BITS_W-1:0]  s_eff;
  logic [SET_W:0]                    one_sh;
  logic [SET_W-1:0]                  set_mask;
  logic [SET_W-1:0]                  set_in;
  logic [6:0]                        tag_shift;
  logic [ADDR_WIDTH-1:0]             tag_in;
  logic [WC_W-1:0]                   n_eff;
  logic [MAX_WAYS-1:0]               in_use;

  // set row memories and read port
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem  [DEPTH];
  logic [MAX_WAYS-1:0]                 vld_mem  [DEPTH];
  logic [MAX_WAYS-1:0][WAY_W-1:0]      age_mem  [DEPTH];
  logic [DEPTH-1:0]                    row_init;
  logic [SET_W-1:0]                    rd_addr;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag;
  logic [MAX_WAYS-1:0]                 rd_vld;
  logic [MAX_WAYS-1:0][WAY_W-1:0]      rd_age;
  logic                                rd_init;
  logic [MAX_WAYS-1:0]                 row_vld;
  logic [MAX_WAYS-1:0][WAY_W-1:0]      row_age;

  // lookup results
  logic [WAY_W-1:0]                    victim;
  logic [MAX_WAYS-1:0]                 vld_next;
  logic [MAX_WAYS-1:0][WAY_W-1:0]      age_next;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_next;
  lrusc_pkg::lookup_t                  result;
  logic [1:0]                          hits_next;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= lrusc_pkg::SET_BITS_RST;
      block_bits <= lrusc_pkg::BLOCK_BITS_RST;
      ways       <= lrusc_pkg::WAYS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrusc_pkg::CFG_SET_BITS:   set_bits   <= cfg_data[lrusc_pkg::SET_BITS_W-1:0];
        lrusc_pkg::CFG_BLOCK_BITS: block_bits <= cfg_data;
        lrusc_pkg::CFG_WAYS:       ways       <= cfg_data[lrusc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // split the address into set index and tag
  always_comb begin
    addr      = address[ADDR_WIDTH-1:0];
    s_eff     = (set_bits > SET_CAP) ? SET_CAP : set_bits;
    one_sh    = (SET_W + 1)'(1) << s_eff;
    set_mask  = SET_W'(one_sh - 1'b1);
    set_in    = SET_W'(addr >> block_bits) & set_mask;
    tag_shift = {4'd0, s_eff} + {1'b0, block_bits};
    tag_in    = addr >> tag_shift;
  end

  // ways in use
  always_comb begin
    priority if (ways == '0) begin
      n_eff = WC_W'(1);
    end else if (WC_W'(ways) > WAY_CAP) begin
      n_eff = WAY_CAP;
    end else begin
      n_eff = WC_W'(ways);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = WC_W'(w) < n_eff;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lrusc_pkg::ST_IDLE: if (in_valid) state_next = lrusc_pkg::ST_EVAL;
      lrusc_pkg::ST_EVAL: if (!out_valid || !out_stall) state_next = lrusc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    do_eval  = 1'b0;
    rd_addr  = set_q;
    unique case (state)
      lrusc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        rd_addr  = set_in;
      end
      lrusc_pkg::ST_EVAL: begin
        do_eval = !out_valid || !out_stall;
      end
    endcase
    wr_en = do_eval && (kind_q != lrusc_pkg::KIND_FETCH);
  end

  // state, latched access and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrusc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_eval) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q <= lrusc_pkg::kind_t'(kind);
      set_q  <= set_in;
      tag_q  <= tag_in;
    end
  end

  // row written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      rd_init  <= 1'b0;
    end else begin
      rd_init <= row_init[rd_addr];
      if (wr_en) begin
        row_init[set_q] <= 1'b1;
      end
    end
  end

  // set row memories: registered read, write-back of the evaluated row
  always_ff @(posedge clk) begin
    rd_tag <= tag_mem[rd_addr];
    rd_vld <= vld_mem[rd_addr];
    rd_age <= age_mem[rd_addr];
    if (wr_en) begin
      tag_mem[set_q] <= tag_next;
      vld_mem[set_q] <= vld_next;
      age_mem[set_q] <= age_next;
    end
  end

  // a never written row reads as empty
  assign row_vld = rd_init ? rd_vld : '0;
  assign row_age = rd_init ? rd_age : '0;

  lrusc_way_select #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .WAY_W      (WAY_W)
  ) u_way_select (
    .in_use     (in_use),
    .valid      (row_vld),
    .age        (row_age),
    .tag        (rd_tag),
    .key        (tag_q),
    .victim     (victim),
    .valid_next (vld_next),
    .age_next   (age_next),
    .result     (result)
  );

  // fill the victim tag on a miss
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      tag_next[w] = (!result.hit && (WAY_W'(w) == victim)) ? tag_q : rd_tag[w];
    end
    hits_next = result.hit ? 2'd1 : 2'd0;
    if (kind_q == lrusc_pkg::KIND_MODIFY) begin
      hits_next = hits_next + 2'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (do_eval) begin
      if (kind_q == lrusc_pkg::KIND_FETCH) begin
        hit_count   <= 2'd0;
        miss_count  <= 1'b0;
        evict_count <= 1'b0;
      end else begin
        hit_count   <= hits_next;
        miss_count  <= !result.hit;
        evict_count <= result.evict;
      end
    end
  end

endmodule

// ===== hdl/lrusc_way_select.sv =====
// hit detection, victim choice and lru age update for one set row
// depends on lrusc_pkg for default geometry and the lookup outcome struct
module lrusc_way_select #(
  parameter int MAX_WAYS   = lrusc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = lrusc_pkg::DEF_ADDR_WIDTH,
  parameter int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS-1:0]                  in_use,
  input  logic [MAX_WAYS-1:0]                  valid,
  input  logic [MAX_WAYS-1:0][WAY_W-1:0]       age,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag,
  input  logic [ADDR_WIDTH-1:0]                key,
  output logic [WAY_W-1:0]                     victim,
  output logic [MAX_WAYS-1:0]                  valid_next,
  output logic [MAX_WAYS-1:0][WAY_W-1:0]       age_next,
  output lrusc_pkg::lookup_t                   result
);

  localparam logic [WAY_W-1:0] AGE_MAX = WAY_W'(MAX_WAYS - 1);

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] hit_age;
  logic             free;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] best_way;
  logic [WAY_W-1:0] best_age;

  // first matching in-use way
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && in_use[w] && valid[w] && (tag[w] == key)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    hit_age = age[hit_way];
  end

  // lowest free way, and oldest valid way with ties to the lowest
  always_comb begin
    free     = 1'b0;
    free_way = '0;
    best_way = '0;
    best_age = age[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!free && in_use[w] && !valid[w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && valid[w] && (age[w] > best_age)) begin
        best_age = age[w];
        best_way = WAY_W'(w);
      end
    end
  end

  // chosen way for this access
  always_comb begin
    priority if (hit) begin
      victim = hit_way;
    end else if (free) begin
      victim = free_way;
    end else begin
      victim = best_way;
    end
  end

  // chosen way becomes most recent, valid lines younger than the hit (all on a miss) age by one, saturating
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      valid_next[w] = valid[w];
      age_next[w]   = age[w];
      if (WAY_W'(w) == victim) begin
        valid_next[w] = 1'b1;
        age_next[w]   = '0;
      end else if (in_use[w] && valid[w] && (!hit || (age[w] < hit_age))
                   && (age[w] < AGE_MAX)) begin
        age_next[w] = age[w] + 1'b1;
      end
    end
  end

  assign result.hit   = hit;
  assign result.evict = !hit && !free;

endmodule
